>>> rtl/core/rpc_pkg.sv
package rpc_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int DATA_WIDTH_DEF = 16;

  // integer headroom above the fraction bits: sign, 16 bits of input range,
  // CORDIC gain growth and one spare
  localparam int GUARD_BITS = 19;

  localparam int TABLE_LEN = 24;

  // gain correction K with 32 fraction bits, about 0.6072529
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam logic [15:0] MAG_MAX = 16'd46341;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic CMD_TO_POLAR = 1'b0;
  localparam logic CMD_TO_RECT  = 1'b1;

  // side data that rides along with the x/y datapath
  typedef struct packed {
    logic        cmd;       // CMD_TO_POLAR or CMD_TO_RECT
    logic        axis;      // vectoring input lies on the x axis
    logic        axis_neg;  // ... on the negative side
    logic [15:0] axis_mag;  // |x| for the axis case
    logic [31:0] z;         // angle accumulator, 2^32 per turn
  } tag_t;

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rpc_front.sv
module rpc_front #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
  parameter int W          = rpc_pkg::DATA_WIDTH_DEF + rpc_pkg::GUARD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic [14:0]         in_mag,
  input  logic signed [15:0]  in_angle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output rpc_pkg::tag_t       out_tag
);

  localparam int SH = 32 - DATA_WIDTH;
  localparam logic [47:0] ROUND = (SH > 0) ? (48'd1 << ((SH > 0) ? SH - 1 : 0)) : 48'd0;

  // stage A: input register plus magnitude * gain
  logic               a_valid;
  logic               a_ready;
  logic               a_cmd;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_angle;
  logic [46:0]        a_prod;

  // stage B: starting point for the cell chain
  logic               b_ready;
  logic [47:0]        prod_rnd;
  logic signed [W-1:0] rot_mag;
  logic signed [16:0] ang17;
  logic signed [16:0] ang_adj;
  logic               flip;
  logic signed [16:0] xs;
  logic signed [16:0] ys;
  logic signed [16:0] xv;
  logic signed [16:0] yv;
  logic               neg;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  rpc_pkg::tag_t      tag_next;

  assign a_ready  = !a_valid || b_ready;
  assign b_ready  = !out_valid || out_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_cmd   <= in_cmd;
      a_x     <= in_x;
      a_y     <= in_y;
      a_angle <= in_angle;
      a_prod  <= 47'(in_mag) * 47'(rpc_pkg::GAIN_Q32);
    end
  end

  always_comb begin
    // rotation: scaled magnitude, fold angles beyond a quarter turn
    prod_rnd = 48'(a_prod) + ROUND;
    rot_mag  = W'(prod_rnd >> SH);
    ang17    = 17'(a_angle);
    flip     = (ang17 > 17'sd16384) || (ang17 < -17'sd16384);
    if (!flip) begin
      ang_adj = ang17;
    end else if (ang17 > 17'sd0) begin
      ang_adj = ang17 - 17'sd32768;
    end else begin
      ang_adj = ang17 + 17'sd32768;
    end

    // vectoring: mirror the left half plane
    xs  = 17'(a_x);
    ys  = 17'(a_y);
    neg = a_x[15];
    xv  = neg ? -xs : xs;
    yv  = neg ? -ys : ys;

    tag_next.cmd      = a_cmd;
    tag_next.axis     = (a_cmd == rpc_pkg::CMD_TO_POLAR) && (a_y == 16'sd0);
    tag_next.axis_neg = neg;
    tag_next.axis_mag = xv[15:0];

    if (a_cmd == rpc_pkg::CMD_TO_RECT) begin
      x_next     = flip ? -rot_mag : rot_mag;
      y_next     = '0;
      tag_next.z = {ang_adj[15:0], 16'h0000};
    end else begin
      x_next     = W'(xv) <<< DATA_WIDTH;
      y_next     = W'(yv) <<< DATA_WIDTH;
      tag_next.z = neg ? 32'h8000_0000 : 32'h0000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      out_x   <= x_next;
      out_y   <= y_next;
      out_tag <= tag_next;
    end
  end

endmodule

>>> rtl/core/rpc_cell.sv
module rpc_cell #(
  parameter int STAGE = 0,
  parameter int W     = rpc_pkg::DATA_WIDTH_DEF + rpc_pkg::GUARD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  rpc_pkg::tag_t       in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output rpc_pkg::tag_t       out_tag
);

  localparam logic [31:0] ATAN = rpc_pkg::ATAN_TURN32[STAGE];

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic                up;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  rpc_pkg::tag_t       tag_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dx = in_y >>> STAGE;
    dy = in_x >>> STAGE;
    // rotation steers by the residual angle, vectoring by the sign of y
    up = (in_tag.cmd == rpc_pkg::CMD_TO_RECT) ? !in_tag.z[31] : in_y[W-1];
    tag_next = in_tag;
    if (up) begin
      x_next     = in_x - dx;
      y_next     = in_y + dy;
      tag_next.z = in_tag.z - ATAN;
    end else begin
      x_next     = in_x + dx;
      y_next     = in_y - dy;
      tag_next.z = in_tag.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_x   <= x_next;
      out_y   <= y_next;
      out_tag <= tag_next;
    end
  end

endmodule

>>> rtl/core/rpc_back.sv
module rpc_back #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
  parameter int W          = rpc_pkg::DATA_WIDTH_DEF + rpc_pkg::GUARD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  rpc_pkg::tag_t       in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_mag,
  output logic [15:0]         out_angle,
  output logic [15:0]         out_x,
  output logic [15:0]         out_y
);

  localparam logic [63:0] HALF_U = 64'd1 << (DATA_WIDTH - 1);
  localparam logic signed [63:0] HALF_S = 64'sd1 <<< (DATA_WIDTH - 1);

  // stage 1: low half of magnitude * gain
  logic                v1;
  logic                r1;
  logic [63:0]         p1_lo;
  logic [31:0]         p1_vh;
  logic signed [W-1:0] p1_x;
  logic signed [W-1:0] p1_y;
  rpc_pkg::tag_t       p1_tag;
  logic [63:0]         m64;

  // stage 2: high half
  logic                v2;
  logic                r2;
  logic [63:0]         p2_hi;
  logic [31:0]         p2_lo_hi;
  logic signed [W-1:0] p2_x;
  logic signed [W-1:0] p2_y;
  rpc_pkg::tag_t       p2_tag;

  // stage 3: round, saturate, select
  logic                r3;
  logic [63:0]         mag_sum;
  logic [63:0]         mag_full;
  logic [31:0]         ang_sum;
  logic signed [63:0]  xr;
  logic signed [63:0]  yr;
  logic [15:0]         mag_next;
  logic [15:0]         angle_next;
  logic [15:0]         x_next;
  logic [15:0]         y_next;

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  assign m64 = in_x[W-1] ? 64'd0 : 64'($unsigned(in_x));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      p1_lo  <= 64'(m64[31:0]) * 64'(rpc_pkg::GAIN_Q32);
      p1_vh  <= m64[63:32];
      p1_x   <= in_x;
      p1_y   <= in_y;
      p1_tag <= in_tag;
    end
    if (v1 && r2) begin
      p2_hi    <= 64'(p1_vh) * 64'(rpc_pkg::GAIN_Q32);
      p2_lo_hi <= p1_lo[63:32];
      p2_x     <= p1_x;
      p2_y     <= p1_y;
      p2_tag   <= p1_tag;
    end
  end

  always_comb begin
    mag_sum  = p2_hi + 64'(p2_lo_hi) + HALF_U;
    mag_full = mag_sum >> DATA_WIDTH;
    ang_sum  = p2_tag.z + 32'h0000_8000;
    xr       = (64'(p2_x) + HALF_S) >>> DATA_WIDTH;
    yr       = (64'(p2_y) + HALF_S) >>> DATA_WIDTH;

    mag_next   = '0;
    angle_next = '0;
    x_next     = '0;
    y_next     = '0;
    if (p2_tag.cmd == rpc_pkg::CMD_TO_RECT) begin
      x_next = rpc_pkg::sat16(xr);
      y_next = rpc_pkg::sat16(yr);
    end else if (p2_tag.axis) begin
      mag_next   = p2_tag.axis_mag;
      angle_next = p2_tag.axis_neg ? 16'h8000 : 16'h0000;
    end else begin
      mag_next   = (mag_full > 64'(rpc_pkg::MAG_MAX)) ? rpc_pkg::MAG_MAX : mag_full[15:0];
      angle_next = ang_sum[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      out_mag   <= mag_next;
      out_angle <= angle_next;
      out_x     <= x_next;
      out_y     <= y_next;
    end
  end

endmodule

>>> rtl/core/rect_polar_converter.sv
// Rectangular <-> polar converter, pipelined CORDIC.
//
// Input channel s_*: s_tuser picks the direction per item (0: x,y to
// magnitude/angle, 1: magnitude/angle to x,y). Output channel m_*: one
// result item for every input item, in order. Angles use 65536 units per
// turn on both sides; the unused half of each result is zero.
//
// Pipeline: two front stages (gain multiply, quadrant fold), one CORDIC
// cell per iteration, three back stages (two 32x32 gain products, round
// and saturate). Throughput is one item per cycle as long as the output
// is not stalled by a low m_tready.
//
// Every stage has its own valid bit and advances when its successor is
// empty or moving, so bubbles are squeezed out while m_tready is low and
// s_tready stays high until all ITERATIONS + 5 stages hold items.
// rst (synchronous) clears all valid bits; data registers are not reset.
module rect_polar_converter #(
  parameter int ITERATIONS = rpc_pkg::ITERATIONS_DEF,
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // x_in[15:0], y_in[31:16], mag_in[46:32], angle_in[62:47], 0
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // mag_out[15:0], angle_out[31:16], x_out[47:32], y_out[63:48]
);

  localparam int W = DATA_WIDTH + rpc_pkg::GUARD_BITS;

  logic                cv [ITERATIONS+1];
  logic                cr [ITERATIONS+1];
  logic signed [W-1:0] cx [ITERATIONS+1];
  logic signed [W-1:0] cy [ITERATIONS+1];
  rpc_pkg::tag_t       ct [ITERATIONS+1];

  logic [15:0] mag_out;
  logic [15:0] angle_out;
  logic [15:0] x_out;
  logic [15:0] y_out;

  rpc_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .W          (W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_x      (s_tdata[15:0]),
    .in_y      (s_tdata[31:16]),
    .in_mag    (s_tdata[46:32]),
    .in_angle  (s_tdata[62:47]),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_x     (cx[0]),
    .out_y     (cy[0]),
    .out_tag   (ct[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    rpc_cell #(
      .STAGE (i),
      .W     (W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_tag    (ct[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_tag   (ct[i+1])
    );
  end

  rpc_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .W          (W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[ITERATIONS]),
    .in_ready  (cr[ITERATIONS]),
    .in_x      (cx[ITERATIONS]),
    .in_y      (cy[ITERATIONS]),
    .in_tag    (ct[ITERATIONS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mag   (mag_out),
    .out_angle (angle_out),
    .out_x     (x_out),
    .out_y     (y_out)
  );

  assign m_tdata = {y_out, x_out, angle_out, mag_out};

  // a result is either polar or rectangular, never both
  a_one_half: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[63:32] != 32'd0) |-> (m_tdata[31:0] == 32'd0))
    else $error("polar and rectangular halves both nonzero");

  // magnitude stays within the saturation limit
  a_mag_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= rpc_pkg::MAG_MAX))
    else $error("magnitude above limit");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

>>> tb/sv/coord_check_pkg.sv
`timescale 1ns / 100ps

package coord_check_pkg;

  import rpc_pkg::CMD_TO_POLAR;

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam bit [63:0] GAIN = 64'd2608131496;
  localparam bit [15:0] MAG_LIMIT = 16'd46341;

  // atan(2^-i), 2^32 per turn
  localparam bit [31:0] TURN_ATAN [STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct {
    bit               cmd;
    bit signed [15:0] x;
    bit signed [15:0] y;
    bit        [14:0] mag;
    bit signed [15:0] angle;
  } coord_in_t;

  typedef struct {
    bit        [15:0] mag;
    bit signed [15:0] angle;
    bit signed [15:0] x;
    bit signed [15:0] y;
  } coord_out_t;

  typedef struct {
    coord_in_t  src;
    coord_out_t res;
  } awaited_t;

  function automatic bit signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic coord_out_t predict_coords(coord_in_t it);
    coord_out_t r;
    longint x, y, dx, dy, a, zs;
    bit [31:0] z, zr;
    bit [63:0] m, prod, rnd;
    r = '{default: '0};
    if (it.cmd == CMD_TO_POLAR) begin
      x = it.x;
      y = it.y;
      if (y == 0) begin
        r.mag = 16'(x < 0 ? -x : x);
        r.angle = (x < 0) ? 16'sh8000 : 16'sh0000;
      end else begin
        z = '0;
        // fold the left half plane by half a turn
        if (x < 0) begin
          x = -x;
          y = -y;
          z = 32'h8000_0000;
        end
        x = x <<< FRAC;
        y = y <<< FRAC;
        for (int i = 0; i < STEPS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx; y -= dy; z += TURN_ATAN[i];
          end else begin
            x -= dx; y += dy; z -= TURN_ATAN[i];
          end
        end
        m = (x < 0) ? 64'd0 : 64'(x);
        rnd = (m >> 32) * GAIN + (((m & 64'hFFFF_FFFF) * GAIN) >> 32)
              + (64'd1 << (FRAC - 1));
        rnd = rnd >> FRAC;
        r.mag = (rnd > 64'(MAG_LIMIT)) ? MAG_LIMIT : rnd[15:0];
        zr = z + 32'h8000;
        r.angle = zr[31:16];
      end
    end else begin
      prod = 64'(it.mag) * GAIN;
      x = longint'((prod + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
      y = 0;
      a = it.angle;
      // beyond +-90 degrees: start on the negative x axis
      if (a > 16384 || a < -16384) begin
        x = -x;
        a = (a > 0) ? a - 32768 : a + 32768;
      end
      zs = a * 65536;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (zs >= 0) begin
          x -= dx; y += dy; zs -= longint'(TURN_ATAN[i]);
        end else begin
          x += dx; y -= dy; zs += longint'(TURN_ATAN[i]);
        end
      end
      r.x = clamp16((x + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      r.y = clamp16((y + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    end
    return r;
  endfunction

  class coord_tracker;
    awaited_t awaited_coords[$];
    int mismatches = 0;
    int checked = 0;
    int polar_seen = 0;
    int axis_seen = 0;
    int rect_seen = 0;

    function void note_accepted(coord_in_t it);
      awaited_t w;
      w.src = it;
      w.res = predict_coords(it);
      awaited_coords.push_back(w);
      if (it.cmd == CMD_TO_POLAR) begin
        polar_seen++;
        if (it.y == 0) axis_seen++;
      end else begin
        rect_seen++;
      end
    endfunction

    function void check_result(bit [63:0] word);
      awaited_t w;
      coord_out_t got;
      got.mag = word[15:0];
      got.angle = word[31:16];
      got.x = word[47:32];
      got.y = word[63:48];
      checked++;
      if (awaited_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result mag=%0d ang=%0d x=%0d y=%0d",
                   got.mag, got.angle, got.x, got.y);
        return;
      end
      w = awaited_coords.pop_front();
      if (got.mag != w.res.mag || got.angle != w.res.angle ||
          got.x != w.res.x || got.y != w.res.y) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: cmd=%0d x=%0d y=%0d mag=%0d ang=%0d: ",
                    "exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d (mag/ang/x/y)"},
                   w.src.cmd, w.src.x, w.src.y, w.src.mag, w.src.angle,
                   w.res.mag, w.res.angle, w.res.x, w.res.y,
                   got.mag, got.angle, got.x, got.y);
      end
    endfunction

    function int outstanding();
      return awaited_coords.size();
    endfunction

    function bit clean();
      return mismatches == 0 && awaited_coords.size() == 0;
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import rpc_pkg::*;
  import coord_check_pkg::*;

  // cycles with no item moving on either side before the run is called hung;
  // worst legal gap is a source or sink stall plus the pipe latency
  localparam int QUIET_LIMIT = 1000;
  localparam int PIPE_LATENCY = ITERATIONS_DEF + 5;
  localparam int RANDOM_ITEMS = 1000;
  localparam int STEADY_TAIL = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // x_in[15:0], y_in[31:16], mag_in[46:32], angle_in[62:47], 0
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // mag_out[15:0], angle_out[31:16], x_out[47:32], y_out[63:48]

  // set once the last stretch starts: no idling on either side from then on
  bit steady = 1'b0;

  coord_tracker tracker = new();

  rect_polar_converter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Item with chosen live fields; the fields the command ignores carry noise.
  function automatic coord_in_t pair_item(bit cmd, int a, int b);
    coord_in_t it;
    it.cmd = cmd;
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.mag = 15'($urandom);
    it.angle = 16'($urandom);
    if (cmd == CMD_TO_POLAR) begin
      it.x = 16'(a);
      it.y = 16'(b);
    end else begin
      it.mag = 15'(a);
      it.angle = 16'(b);
    end
    return it;
  endfunction

  // Random item, biased toward the corners of the math: axis points, tiny
  // vectors, full-scale x, extreme magnitudes, angles at +-90 and +-180 deg.
  function automatic coord_in_t random_item();
    coord_in_t it;
    it = pair_item($urandom_range(0, 1), $urandom, $urandom);
    case ($urandom_range(0, 11))
      0: it.y = '0;
      1: begin
        it.x = 16'($urandom_range(0, 16) - 8);
        it.y = 16'($urandom_range(0, 16) - 8);
      end
      2: it.x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      3: it.mag = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
      4: it.angle = 16'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 4) - 2);
      5: it.angle = 16'(32768 + $urandom_range(0, 4) - 2);
      default: ;
    endcase
    return it;
  endfunction

  // Present one item and hold it until the converter takes it. An idle gap
  // comes first, roughly one time in gap_odds.
  task automatic send_item(input coord_in_t it, input int gap_odds);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= {1'b0, it.angle, it.mag, it.y, it.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Output side backpressure: runs of ready broken by stalls, none once steady is set.
  initial begin : sink
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20)) @(posedge clk);
      if (!steady && $urandom_range(0, 1) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Accepted inputs feed the predictor; values read here are pre-edge.
  always @(posedge clk) begin : watch_in
    coord_in_t seen;
    if (!rst && s_tvalid && s_tready) begin
      seen.cmd = s_tuser;
      seen.x = s_tdata[15:0];
      seen.y = s_tdata[31:16];
      seen.mag = s_tdata[46:32];
      seen.angle = s_tdata[62:47];
      tracker.note_accepted(seen);
    end
  end

  always @(posedge clk) begin : watch_out
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles, %0d results still owed",
             QUIET_LIMIT, tracker.outstanding());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    coord_in_t plan[$];
    int gap_odds;
    int k;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: vectoring on and off the axes, corners, both sides of 180 deg
    plan.push_back(pair_item(CMD_TO_POLAR, 0, 0));
    plan.push_back(pair_item(CMD_TO_POLAR, 32767, 0));
    plan.push_back(pair_item(CMD_TO_POLAR, -32768, 0));
    plan.push_back(pair_item(CMD_TO_POLAR, -1, 0));
    plan.push_back(pair_item(CMD_TO_POLAR, 0, 32767));
    plan.push_back(pair_item(CMD_TO_POLAR, 0, -32768));
    plan.push_back(pair_item(CMD_TO_POLAR, 32767, 32767));
    plan.push_back(pair_item(CMD_TO_POLAR, -32768, -32768));
    plan.push_back(pair_item(CMD_TO_POLAR, -32768, 32767));
    plan.push_back(pair_item(CMD_TO_POLAR, 32767, -32768));
    plan.push_back(pair_item(CMD_TO_POLAR, -32768, 1));
    plan.push_back(pair_item(CMD_TO_POLAR, -32768, -1));
    plan.push_back(pair_item(CMD_TO_POLAR, 3, 4));
    plan.push_back(pair_item(CMD_TO_POLAR, 1, -1));
    // rotation: zero and full magnitude, both sides of +-90 deg, +-180 deg
    plan.push_back(pair_item(CMD_TO_RECT, 0, 0));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, 0));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, 16384));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, 16385));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, -16384));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, -16385));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, -32768));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, 32767));
    plan.push_back(pair_item(CMD_TO_RECT, 32767, 8192));
    plan.push_back(pair_item(CMD_TO_RECT, 1, -8192));

    for (k = 0; k < RANDOM_ITEMS; k++) plan.push_back(random_item());

    gap_odds = 4;
    for (k = 0; k < plan.size(); k++) begin
      // change the source idling pattern every 100 items, sometimes none
      if (k % 100 == 0 && k != 0) begin
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 2;
          2: gap_odds = 4;
          default: gap_odds = 8;
        endcase
      end
      if (k >= plan.size() - STEADY_TAIL) begin
        steady = 1'b1;
        gap_odds = 0;
      end
      send_item(plan[k], gap_odds);
    end
    s_tvalid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    // anything arriving now would be a stray result
    repeat (3 * PIPE_LATENCY) @(posedge clk);

    $display("covered %0d items: %0d to polar (%0d on the x axis), %0d to rectangular",
             tracker.polar_seen + tracker.rect_seen, tracker.polar_seen,
             tracker.axis_seen, tracker.rect_seen);
    $display("checked %0d results, %0d mismatches, %0d never arrived",
             tracker.checked, tracker.mismatches, tracker.outstanding());
    if (tracker.clean()) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rpc_pkg.sv
rtl/core/rpc_front.sv
rtl/core/rpc_cell.sv
rtl/core/rpc_back.sv
rtl/core/rect_polar_converter.sv
tb/sv/coord_check_pkg.sv
tb/sv/tb_top.sv
